/* sv/vector_linear_tween_slots_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vector tween slot pool
// Shared checking helpers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef VECTOR_LINEAR_TWEEN_SLOTS_CORE_DEFINES_SVH
`define VECTOR_LINEAR_TWEEN_SLOTS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VLTS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vlts assertion failed");
`define VLTS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("vlts forbidden condition");
`else
`define VLTS_ASSERT(label, clk, rst, prop)
`define VLTS_NEVER(label, clk, rst, cond)
`endif
`endif

/* sv/vlts_pkg.sv */
// ----------------------------------------------------------------------------
// vlts_pkg
// Types, codes and helpers shared by the tween slot pool.
// ----------------------------------------------------------------------------
package vlts_pkg;

  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_WALK,
    ST_REG_LINK,
    ST_REG_WAIT,
    ST_REL_WALK,
    ST_TICK_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic fin;
  } lane_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/vlts_div.sv */
// ----------------------------------------------------------------------------
// vlts_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module vlts_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        magnitude,
  input  logic               negative,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quotient
);
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic        neg;
  logic [16:0] r2;
  logic        ge;
  logic [15:0] rem_next;

  always_comb begin
    r2       = {rem, quo[31]};
    ge       = r2 >= {1'b0, dvs};
    rem_next = ge ? 16'(r2 - {1'b0, dvs}) : r2[15:0];
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= magnitude;
        rem  <= '0;
        dvs  <= divisor;
        neg  <= negative;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[30:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* sv/vlts_lane.sv */
// ----------------------------------------------------------------------------
// vlts_lane
// One vector component: stored value, destination and step for every slot.
// ----------------------------------------------------------------------------
module vlts_lane #(
  parameter int POOL_ENTRIES = 15,
  localparam int SW = $clog2(POOL_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  vlts_pkg::lane_cmd_t cmd,
  input  logic [SW-1:0]       slot,
  input  logic signed [31:0]  start_val,
  input  logic signed [31:0]  dest_val,
  input  logic [15:0]         dur,
  output logic signed [31:0]  result,
  output logic                busy
);
  import vlts_pkg::*;

  logic signed [31:0] value_mem [POOL_ENTRIES];
  logic signed [31:0] dest_mem  [POOL_ENTRIES];
  logic signed [31:0] step_mem  [POOL_ENTRIES];
  logic [SW-1:0]      load_slot;
  logic signed [31:0] diff;
  logic [31:0]        mag;
  logic               div_done;
  logic signed [31:0] quot;

  always_comb begin
    diff = sat32(33'(dest_val) - 33'(start_val));
    mag  = diff[31] ? 32'(-diff) : 32'(diff);
  end

  vlts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .magnitude (mag),
    .negative  (diff[31]),
    .divisor   (dur),
    .busy      (busy),
    .done      (div_done),
    .quotient  (quot)
  );

  assign result = cmd.fin ? dest_mem[slot]
                          : sat32(33'(value_mem[slot]) + 33'(step_mem[slot]));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_mem[slot] <= start_val;
      dest_mem[slot]  <= dest_val;
      load_slot       <= slot;
    end
    if (cmd.tick) begin
      value_mem[slot] <= result;
    end
    if (div_done) begin
      step_mem[load_slot] <= quot;
    end
  end
endmodule

/* sv/vector_linear_tween_slots_core.sv */
// ----------------------------------------------------------------------------
// vector_linear_tween_slots_core
// Pool of tween slots moving 4-component Q16.16 vectors toward targets.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group: s_tuser carries the request kind and s_tdata
// the target, duration, start and destination vectors. Results leave on the
// m_ group, one per reported slot, m_tuser marking a finished slot and m_tlast
// the final result of a request.
// A tick walks the active list one slot per cycle while the output register
// can take a result, waiting for it to drain when m_tready is low; the next
// request is taken once the walk ends. A release walks the list until it
// finds the target or reaches the end. An accepted registration runs four
// lane dividers in parallel, one quotient bit per cycle, and the next request
// is taken once the dividers finish; a refused one (no free slot or zero
// duration) gives its single result the cycle after acceptance.
// The block takes one request at a time; s_tready is high when idle and the
// output register is free or being emptied.
// Reset empties the list and frees all slots; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "vector_linear_tween_slots_core_defines.svh"

module vector_linear_tween_slots_core #(
  parameter int POOL_ENTRIES = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_id, duration, start_x, start_y, start_z, start_w,
  // dest_x, dest_y, dest_z, dest_w
  input  logic [287:0] s_tdata,
  // req_type
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_target, out_x, out_y, out_z, out_w
  output logic [143:0] m_tdata,
  // finished
  output logic         m_tuser,
  output logic         m_tlast
);
  import vlts_pkg::*;

  localparam int SW = $clog2(POOL_ENTRIES);

  state_t        state, state_next;
  logic          busy_bits [POOL_ENTRIES];
  logic [SW-1:0] link      [POOL_ENTRIES];
  logic [SW-1:0] tail;
  logic [15:0]   tgt_mem   [POOL_ENTRIES];
  logic [15:0]   dur_mem   [POOL_ENTRIES];
  logic [15:0]   ela_mem   [POOL_ENTRIES];
  logic [SW-1:0] cur, prev, free_q;
  logic [15:0]   tid_q;
  logic [15:0]   dur_q;
  logic [SW-1:0] free_slot;
  logic          has_free;
  logic          accept, can_emit, lanes_busy, hit, fin;
  logic          emit_refuse, emit_tick;
  lane_cmd_t     cmd;
  logic [SW-1:0] lane_slot;
  logic signed [31:0] lane_res [4];
  logic [3:0]    lane_busy;

  wire [1:0]  req  = s_tuser;
  wire [15:0] tid  = s_tdata[15:0];
  wire [15:0] dur  = s_tdata[31:16];

  assign accept     = s_tvalid && s_tready;
  assign can_emit   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && can_emit;
  assign lanes_busy = |lane_busy;
  assign hit        = tgt_mem[cur] == tid_q;
  assign fin        = ela_mem[cur] == dur_mem[cur];

  assign emit_refuse = (state == ST_IDLE) && accept && (req == REQ_REGISTER)
                       && (!has_free || dur == 16'd0);
  assign emit_tick   = (state == ST_TICK_WALK) && (cur != '0) && can_emit;

  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = POOL_ENTRIES - 1; i >= 1; i--) begin
      if (!busy_bits[i]) begin
        free_slot = SW'(i);
        has_free  = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (req == REQ_REGISTER && has_free && dur != 16'd0) begin
            state_next = ST_REG_WALK;
          end else if (req == REQ_TICK) begin
            state_next = ST_TICK_WALK;
          end else if (req == REQ_RELEASE) begin
            state_next = ST_REL_WALK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REG_WALK: begin
        if (cur == '0 || hit) state_next = ST_REG_LINK;
      end
      ST_REG_LINK:  state_next = ST_REG_WAIT;
      ST_REG_WAIT: begin
        if (!lanes_busy) state_next = ST_IDLE;
      end
      ST_REL_WALK: begin
        if (cur == '0 || hit) state_next = ST_IDLE;
      end
      ST_TICK_WALK: begin
        if (cur == '0) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Lane commands.
  always_comb begin
    cmd       = '0;
    lane_slot = cur;
    unique case (state)
      ST_IDLE: begin
        lane_slot = free_slot;
        cmd.load  = accept && req == REQ_REGISTER && has_free && dur != 16'd0;
      end
      ST_TICK_WALK: begin
        cmd.fin  = fin;
        cmd.tick = cur != '0 && can_emit;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    vlts_lane #(.POOL_ENTRIES(POOL_ENTRIES)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .slot      (lane_slot),
      .start_val (s_tdata[32 + 32*g +: 32]),
      .dest_val  (s_tdata[160 + 32*g +: 32]),
      .dur       (dur),
      .result    (lane_res[g]),
      .busy      (lane_busy[g])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_refuse || emit_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_refuse) begin
      // Refused registration reports the destination at once.
      m_tdata <= {s_tdata[287:160], tid};
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end else if (emit_tick) begin
      m_tdata <= {lane_res[3], lane_res[2], lane_res[1], lane_res[0], tgt_mem[cur]};
      m_tuser <= fin;
      m_tlast <= link[cur] == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tail     <= '0;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        busy_bits[i] <= 1'b0;
        link[i]      <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          cur   <= link[0];
          prev  <= '0;
          tid_q <= tid;
          dur_q <= dur;
          if (accept && req == REQ_REGISTER) begin
            free_q <= free_slot;
          end
        end
        ST_REG_WALK, ST_REL_WALK: begin
          if (cur != '0) begin
            if (hit) begin
              link[prev]     <= link[cur];
              link[cur]      <= '0;
              busy_bits[cur] <= 1'b0;
              if (tail == cur) tail <= prev;
            end else begin
              prev <= cur;
              cur  <= link[cur];
            end
          end
        end
        ST_REG_LINK: begin
          link[free_q]      <= '0;
          link[tail]        <= free_q;
          tail              <= free_q;
          busy_bits[free_q] <= 1'b1;
          tgt_mem[free_q]   <= tid_q;
          dur_mem[free_q]   <= dur_q;
          ela_mem[free_q]   <= '0;
        end
        ST_TICK_WALK: begin
          if (emit_tick) begin
            cur <= link[cur];
            if (fin) begin
              // The walk carries on past a freed slot.
              link[prev]     <= link[cur];
              link[cur]      <= '0;
              busy_bits[cur] <= 1'b0;
              if (tail == cur) tail <= prev;
            end else begin
              ela_mem[cur] <= ela_mem[cur] + 16'd1;
              prev         <= cur;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `VLTS_ASSERT(a_tail_busy, clk, rst, (tail == '0) || busy_bits[tail])
  `VLTS_ASSERT(a_head_tail, clk, rst, (link[0] == '0) == (tail == '0))
  `VLTS_NEVER(a_idle_div, clk, rst, (state == ST_IDLE) && lanes_busy)
endmodule

/* test/tb_vector_linear_tween_slots_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the vector tween slot pool
// Drives register, tick and release requests into the pool. A behavioural
// slot list inside the bench predicts each reported vector, and every result
// transfer is compared field by field, in order, with that prediction.
// ----------------------------------------------------------------------------
module tb_vector_linear_tween_slots_core;
  import vlts_pkg::*;

  localparam int SLOTS     = 15;
  localparam int N_RANDOM  = 200;
  localparam int WD_LIMIT  = 3000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      tid;
    logic [15:0]      dur;
    logic [3:0][31:0] start;
    logic [3:0][31:0] dest;
  } tween_req_t;

  typedef struct packed {
    logic [15:0]      tid;
    logic [3:0][31:0] vec;
    logic             fin;
    logic             last;
  } vec_report_t;

  typedef struct packed {
    tween_req_t  req;
    logic        typed;
    vec_report_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  vector_linear_tween_slots_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the slot pool.
  bit               slot_used [SLOTS];
  int               slot_next [SLOTS];
  int               list_tail;
  logic [15:0]      slot_tid  [SLOTS];
  logic [3:0][31:0] slot_pos  [SLOTS];
  logic [3:0][31:0] slot_goal [SLOTS];
  logic [3:0][31:0] slot_inc  [SLOTS];
  logic [15:0]      slot_len  [SLOTS];
  logic [15:0]      slot_age  [SLOTS];

  vec_report_t expected_reports[$];
  vec_report_t tick_reports[$];
  stim_row_t   directed[$];
  int          mismatches = 0;
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void drop_from_list(int prev, int s);
    slot_next[prev] = slot_next[s];
    if (list_tail == s) list_tail = prev;
    slot_next[s] = 0;
    slot_used[s] = 1'b0;
  endfunction

  function automatic void release_by_tid(logic [15:0] tid);
    int prev, s, guard;
    prev = 0;
    s = slot_next[0];
    guard = 0;
    while (s != 0 && guard < SLOTS) begin
      if (slot_tid[s] == tid) begin
        drop_from_list(prev, s);
        return;
      end
      prev = s;
      s = slot_next[s];
      guard++;
    end
  endfunction

  // Applies one request to the mirror and leaves its reports in tick_reports.
  function automatic void advance_pool(tween_req_t r);
    int free_s, prev, s, nxt, guard;
    longint diff;
    vec_report_t rep;
    tick_reports.delete();
    case (r.kind)
      REQ_REGISTER: begin
        free_s = 0;
        for (int i = SLOTS - 1; i >= 1; i--) if (!slot_used[i]) free_s = i;
        if (free_s == 0 || r.dur == 0) begin
          rep.tid = r.tid; rep.vec = r.dest; rep.fin = 1'b1; rep.last = 1'b1;
          tick_reports.push_back(rep);
        end else begin
          release_by_tid(r.tid);
          slot_next[free_s] = 0;
          slot_next[list_tail] = free_s;
          list_tail = free_s;
          slot_used[free_s] = 1'b1;
          slot_tid[free_s] = r.tid;
          slot_len[free_s] = r.dur;
          slot_age[free_s] = '0;
          for (int c = 0; c < 4; c++) begin
            diff = longint'($signed(clamp32(longint'($signed(r.dest[c]))
                                           - longint'($signed(r.start[c])))));
            slot_pos[free_s][c]  = r.start[c];
            slot_goal[free_s][c] = r.dest[c];
            slot_inc[free_s][c]  = 32'(diff / longint'(r.dur));
          end
        end
      end
      REQ_TICK: begin
        prev = 0;
        s = slot_next[0];
        guard = 0;
        while (s != 0 && guard < SLOTS) begin
          nxt = slot_next[s];
          rep.tid = slot_tid[s];
          rep.last = 1'b0;
          if (slot_age[s] == slot_len[s]) begin
            slot_pos[s] = slot_goal[s];
            rep.vec = slot_pos[s]; rep.fin = 1'b1;
            drop_from_list(prev, s);
          end else begin
            for (int c = 0; c < 4; c++)
              slot_pos[s][c] = clamp32(longint'($signed(slot_pos[s][c]))
                                       + longint'($signed(slot_inc[s][c])));
            slot_age[s] = slot_age[s] + 16'd1;
            rep.vec = slot_pos[s]; rep.fin = 1'b0;
            prev = s;
          end
          tick_reports.push_back(rep);
          s = nxt;
          guard++;
        end
        if (tick_reports.size() > 0) tick_reports[tick_reports.size() - 1].last = 1'b1;
      end
      REQ_RELEASE: release_by_tid(r.tid);
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [15:0] tid, logic [15:0] dur,
                                  logic [31:0] s_all, logic [31:0] d_all, bit typed);
    stim_row_t row;
    row.req.kind = kind; row.req.tid = tid; row.req.dur = dur;
    row.req.start = {4{s_all}};
    row.req.dest  = {d_all, ~d_all, d_all, ~d_all};
    row.typed = typed;
    row.want.tid = tid; row.want.vec = row.req.dest; row.want.fin = 1'b1; row.want.last = 1'b1;
    directed.push_back(row);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
    endcase
  endfunction

  function automatic tween_req_t random_req();
    tween_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.kind = REQ_REGISTER;
    else if (pick < 80) r.kind = REQ_TICK;
    else if (pick < 95) r.kind = REQ_RELEASE;
    else r.kind = REQ_UNUSED;
    r.tid = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 11));
    case ($urandom_range(0, 19))
      0: r.dur = 16'($urandom());
      1: r.dur = 16'd0;
      default: r.dur = 16'($urandom_range(1, 6));
    endcase
    for (int c = 0; c < 4; c++) begin
      r.start[c] = rand_coord();
      r.dest[c]  = rand_coord();
    end
    return r;
  endfunction

  // Sends one request, then updates the mirror once the transfer is taken.
  task automatic send_req(tween_req_t r, bit typed, vec_report_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {r.dest, r.start, r.dur, r.tid};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    advance_pool(r);
    if (typed) expected_reports.push_back(want);
    else foreach (tick_reports[i]) expected_reports.push_back(tick_reports[i]);
  endtask

  // Result side: random stall bursts until the quiet stretch.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= !rst;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vec_report_t got, want;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      got.tid = m_tdata[15:0];
      for (int c = 0; c < 4; c++) got.vec[c] = m_tdata[16 + 32 * c +: 32];
      got.fin = m_tuser;
      got.last = m_tlast;
      if (expected_reports.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: target %0d x %h y %h z %h w %h fin %b last %b",
                   got.tid, got.vec[0], got.vec[1], got.vec[2], got.vec[3], got.fin, got.last);
      end else begin
        want = expected_reports.pop_front();
        bad = (got.tid != want.tid) || (got.fin != want.fin) || (got.last != want.last);
        for (int c = 0; c < 4; c++) if (got.vec[c] != want.vec[c]) bad = 1'b1;
        if (bad) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tgt %0d %h %h %h %h f%b l%b, got tgt %0d %h %h %h %h f%b l%b",
                     want.tid, want.vec[0], want.vec[1], want.vec[2], want.vec[3],
                     want.fin, want.last, got.tid, got.vec[0], got.vec[1], got.vec[2],
                     got.vec[3], got.fin, got.last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("vector_linear_tween_slots_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    vec_report_t none;
    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0; slot_next[i] = 0; slot_tid[i] = '0; slot_pos[i] = '0;
      slot_goal[i] = '0; slot_inc[i] = '0; slot_len[i] = '0; slot_age[i] = '0;
    end
    list_tail = 0;

    // Tick on an empty pool, zero-duration registrations at the extremes,
    // a saturated difference, a replaced target, releases and the unused kind.
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_REGISTER, 16'hFFFF,  16'd0,     32'h0,          32'h7FFF_FFFF,  1'b1);
    add_row(REQ_REGISTER, 16'h0000,  16'd0,     32'hFFFF_FFFF,  32'h8000_0000,  1'b1);
    add_row(REQ_REGISTER, 16'd5,     16'd1,     32'h8000_0000,  32'h7FFF_FFFF,  1'b0);
    add_row(REQ_REGISTER, 16'd6,     16'hFFFF,  32'h7FFF_FFFF,  32'h8000_0000,  1'b0);
    add_row(REQ_REGISTER, 16'd7,     16'd3,     32'h0001_0000,  32'hFFF0_0000,  1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_REGISTER, 16'd7,     16'd2,     32'h0003_0000,  32'h0000_8000,  1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_RELEASE,  16'd6,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_RELEASE,  16'hABCD,  16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_UNUSED,   16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);
    for (int i = 0; i < 15; i++)
      add_row(REQ_REGISTER, 16'(100 + i), 16'd4, 32'h0,  32'h0010_0000, 1'b0);
    add_row(REQ_TICK,     16'd0,     16'd0,     32'h0,          32'h0,          1'b0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
      end
      if (n == N_RANDOM - 40) quiet = 1'b1;
      send_req(random_req(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed && expected_reports.size() == 0)
      $display("vector_linear_tween_slots_core verification clean");
    else
      $display("vector_linear_tween_slots_core verification failed");
    $finish;
  end

endmodule
